// ===== rtl/core/touch_press_classifier_macros.svh =====
// Assertion macros used by the touch press classifier checker.
`ifndef TOUCH_PRESS_CLASSIFIER_MACROS_SVH
`define TOUCH_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/tpc_pkg.sv =====
// Shared types, constants and field layout of the touch press classifier.
package tpc_pkg;

    // Field widths.
    localparam int PAD_BITS = 13;
    localparam int TIME_W   = 32;
    localparam int THR_W    = 16;
    localparam int PADC_W   = 4;
    localparam int KIND_W   = 3;
    localparam int REG_IDX_W = 2;

    // Configuration reset values.
    localparam logic [THR_W-1:0]  LONG_RESET  = THR_W'(3100);
    localparam logic [THR_W-1:0]  SHORT_RESET = THR_W'(500);
    localparam logic [THR_W-1:0]  MIN_RESET   = THR_W'(90);
    localparam logic [PADC_W-1:0] PADC_RESET  = PADC_W'(13);

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LONG_THRESHOLD  = 2'd0,
        REG_SHORT_THRESHOLD = 2'd1,
        REG_MIN_THRESHOLD   = 2'd2,
        REG_PAD_COUNT       = 2'd3
    } reg_idx_t;

    // Kind of touch end reported with each word.
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_IGNORED = 3'd1,
        KIND_SHORT   = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_INVALID = 3'd4
    } end_kind_t;

    // Configuration register set.
    typedef struct packed {
        logic [THR_W-1:0]  long_threshold_ms;
        logic [THR_W-1:0]  short_threshold_ms;
        logic [THR_W-1:0]  min_threshold_ms;
        logic [PADC_W-1:0] pad_count;
    } cfg_t;

    // One result word; the last member sits in the lowest bits.
    typedef struct packed {
        logic [PAD_BITS-1:0] pads_released;
        logic [PAD_BITS-1:0] pads_pressed;
        logic [PAD_BITS-1:0] pads_in_touch;
        logic [TIME_W-1:0]   duration_ms;
        end_kind_t           end_kind;
        logic                touch_started;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int IN_FIELDS_W = PAD_BITS + TIME_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Bit positions of the result fields in the output tdata.
    localparam int OUT_KIND_LSB  = 1;
    localparam int OUT_DUR_LSB   = OUT_KIND_LSB + KIND_W;
    localparam int OUT_UNION_LSB = OUT_DUR_LSB + TIME_W;
    localparam int OUT_PRESS_LSB = OUT_UNION_LSB + PAD_BITS;
    localparam int OUT_REL_LSB   = OUT_PRESS_LSB + PAD_BITS;

endpackage

// ===== rtl/core/tpc_cfg_regs.sv =====
// Configuration register file of the touch press classifier.
module tpc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [tpc_pkg::THR_W-1:0]      cfg_data,
    output tpc_pkg::cfg_t                  cfg
);

    tpc_pkg::cfg_t cfg_reg;
    tpc_pkg::cfg_t cfg_next;

    // Decode a write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tpc_pkg::reg_idx_t'(cfg_index))
                tpc_pkg::REG_LONG_THRESHOLD:  cfg_next.long_threshold_ms  = cfg_data;
                tpc_pkg::REG_SHORT_THRESHOLD: cfg_next.short_threshold_ms = cfg_data;
                tpc_pkg::REG_MIN_THRESHOLD:   cfg_next.min_threshold_ms   = cfg_data;
                tpc_pkg::REG_PAD_COUNT:
                    cfg_next.pad_count = cfg_data[tpc_pkg::PADC_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_threshold_ms  <= tpc_pkg::LONG_RESET;
            cfg_reg.short_threshold_ms <= tpc_pkg::SHORT_RESET;
            cfg_reg.min_threshold_ms   <= tpc_pkg::MIN_RESET;
            cfg_reg.pad_count          <= tpc_pkg::PADC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/tpc_core.sv =====
// Touch tracking state, duration classification and per-pad edge detection.
module tpc_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [tpc_pkg::PAD_BITS-1:0] mask,
    input  logic [tpc_pkg::TIME_W-1:0]   now,
    input  tpc_pkg::cfg_t                cfg,
    output tpc_pkg::result_t             result
);

    logic                         active_reg;
    logic                         active_next;
    logic [tpc_pkg::TIME_W-1:0]   start_reg;
    logic [tpc_pkg::TIME_W-1:0]   start_next;
    logic [tpc_pkg::PAD_BITS-1:0] seen_reg;
    logic [tpc_pkg::PAD_BITS-1:0] seen_next;
    logic [tpc_pkg::PAD_BITS-1:0] prev_reg;
    logic [tpc_pkg::PAD_BITS-1:0] seen_or;
    logic [tpc_pkg::PAD_BITS-1:0] limit;
    logic [tpc_pkg::TIME_W-1:0]   dur;

    assign seen_or = seen_reg | mask;
    assign dur     = now - start_reg;

    // Pads below the configured count take part in edge detection.
    always_comb
    begin
        for (int i = 0; i < tpc_pkg::PAD_BITS; i++)
        begin
            limit[i] = (32'(cfg.pad_count) > i);
        end
    end

    // Touch start and end, with classification of the ended touch.
    always_comb
    begin
        active_next          = active_reg;
        start_next           = start_reg;
        seen_next            = seen_or;
        result.touch_started = 1'b0;
        result.end_kind      = tpc_pkg::KIND_NONE;
        result.duration_ms   = '0;
        result.pads_in_touch = '0;
        if (!active_reg && (mask != '0))
        begin
            active_next          = 1'b1;
            start_next           = now;
            result.touch_started = 1'b1;
        end
        else if (active_reg && (mask == '0))
        begin
            result.duration_ms   = dur;
            result.pads_in_touch = seen_or;
            priority if (dur < 32'(cfg.min_threshold_ms))
                result.end_kind = tpc_pkg::KIND_IGNORED;
            else if (dur >= 32'(cfg.long_threshold_ms))
                result.end_kind = tpc_pkg::KIND_LONG;
            else if (dur <= 32'(cfg.short_threshold_ms))
                result.end_kind = tpc_pkg::KIND_SHORT;
            else
                result.end_kind = tpc_pkg::KIND_INVALID;
            active_next = 1'b0;
            start_next  = '0;
            seen_next   = '0;
        end
        result.pads_pressed  = mask & ~prev_reg & limit;
        result.pads_released = ~mask & prev_reg & limit;
    end

    // Tracking state advances once per processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
            seen_reg   <= '0;
            prev_reg   <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            start_reg  <= start_next;
            seen_reg   <= seen_next;
            prev_reg   <= mask;
        end
    end

endmodule

// ===== rtl/core/touch_press_classifier.sv =====
// Each accepted input word is captured in the input register, and its result in the result register.
// Throughput: one word per cycle while the output is not stalled, through an input register and a result register.
// A stalled output holds its word while one more input word waits in the input register.
// Reset clears valid flags and touch state and loads the default thresholds.
// Configuration writes take effect on the next clock edge.
module touch_press_classifier (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tpc_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [tpc_pkg::THR_W-1:0]         cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // touched_mask [12:0], now_ms [44:13], zero fill above
    input  logic [tpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // touch_started [0], end_kind [3:1], duration_ms [35:4], pads_in_touch [48:36],
    // pads_pressed [61:49], pads_released [74:62], zero fill above
    output logic [tpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    tpc_pkg::cfg_t                cfg;
    tpc_pkg::result_t             result;
    tpc_pkg::result_t             out_reg;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [tpc_pkg::PAD_BITS-1:0] in_mask_reg;
    logic [tpc_pkg::TIME_W-1:0]   in_now_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_free;
    logic                         in_fire;
    logic                         step;

    tpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .mask   (in_mask_reg),
        .now    (in_now_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Handshake between the input register and the result register.
    always_comb
    begin
        out_free       = !out_valid_reg || m_axis_tready;
        step           = in_valid_reg && out_free;
        s_axis_tready  = !in_valid_reg || out_free;
        in_fire        = s_axis_tvalid && s_axis_tready;
        in_valid_next  = in_fire || (in_valid_reg && !out_free);
        out_valid_next = step || (out_valid_reg && !m_axis_tready);
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_mask_reg <= s_axis_tdata[tpc_pkg::PAD_BITS-1:0];
            in_now_reg  <= s_axis_tdata[tpc_pkg::PAD_BITS +: tpc_pkg::TIME_W];
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tpc_pkg::OUT_TDATA_W'(out_reg);

endmodule

// ===== rtl/core/tpc_checker.sv =====
// Port-level checks of the touch press classifier and their binding.
`include "touch_press_classifier_macros.svh"

module tpc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic                         started;
    logic [tpc_pkg::KIND_W-1:0]   kind;
    logic [tpc_pkg::TIME_W-1:0]   dur;
    logic [tpc_pkg::PAD_BITS-1:0] pads_union;
    logic [tpc_pkg::PAD_BITS-1:0] pressed;
    logic [tpc_pkg::PAD_BITS-1:0] released;

    assign started    = m_axis_tdata[0];
    assign kind       = m_axis_tdata[tpc_pkg::OUT_KIND_LSB +: tpc_pkg::KIND_W];
    assign dur        = m_axis_tdata[tpc_pkg::OUT_DUR_LSB +: tpc_pkg::TIME_W];
    assign pads_union = m_axis_tdata[tpc_pkg::OUT_UNION_LSB +: tpc_pkg::PAD_BITS];
    assign pressed    = m_axis_tdata[tpc_pkg::OUT_PRESS_LSB +: tpc_pkg::PAD_BITS];
    assign released   = m_axis_tdata[tpc_pkg::OUT_REL_LSB +: tpc_pkg::PAD_BITS];

    // A stalled result word stays put.
    `TPC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // A touch cannot start and end on the same sample.
    `TPC_ASSERT_NOW(a_start_xor_end, clk, rst_n, m_axis_tvalid,
        !(started && (kind != tpc_pkg::KIND_NONE)))

    // Without an ended touch the duration and pad union are zero.
    `TPC_ASSERT_NOW(a_idle_fields_zero, clk, rst_n,
        m_axis_tvalid && (kind == tpc_pkg::KIND_NONE),
        (dur == '0) && (pads_union == '0))

    // A pad cannot be pressed and released on the same sample.
    `TPC_ASSERT_NOW(a_edges_disjoint, clk, rst_n, m_axis_tvalid,
        (pressed & released) == '0)

endmodule

bind touch_press_classifier tpc_checker u_tpc_checker (.*);

// ===== bench/touch_press_classifier_tb.sv =====
// Self-checking testbench for the touch press classifier: stream stimulus, prediction and scoreboard.
module touch_press_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 120;
    localparam int SETTLE_CYCLES = 4;

    // Tracks touch state and thresholds, and holds the expected result words in order.
    class press_scoreboard;
        logic [THR_W-1:0]    long_thr;
        logic [THR_W-1:0]    short_thr;
        logic [THR_W-1:0]    min_thr;
        logic [PADC_W-1:0]   pad_cnt;
        bit                  active;
        logic [TIME_W-1:0]   start_ms;
        logic [PAD_BITS-1:0] seen;
        logic [PAD_BITS-1:0] prev;
        result_t             press_reports[$];
        int                  errors;

        function new();
            long_thr  = LONG_RESET;
            short_thr = SHORT_RESET;
            min_thr   = MIN_RESET;
            pad_cnt   = PADC_RESET;
            active    = 1'b0;
            start_ms  = '0;
            seen      = '0;
            prev      = '0;
            errors    = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [THR_W-1:0] value);
            case (idx)
                REG_LONG_THRESHOLD:  long_thr  = value;
                REG_SHORT_THRESHOLD: short_thr = value;
                REG_MIN_THRESHOLD:   min_thr   = value;
                REG_PAD_COUNT:       pad_cnt   = value[PADC_W-1:0];
                default: ;
            endcase
        endfunction

        // Predicts the result word caused by one accepted sample.
        function void note_sample(logic [PAD_BITS-1:0] mask, logic [TIME_W-1:0] now);
            result_t             r;
            logic [TIME_W-1:0]   dur;
            logic [PAD_BITS-1:0] lim;
            int                  n;
            r = '0;
            seen = seen | mask;
            if (!active && mask != '0)
            begin
                active = 1'b1;
                start_ms = now;
                r.touch_started = 1'b1;
            end
            else if (active && mask == '0)
            begin
                dur = now - start_ms;
                r.duration_ms = dur;
                r.pads_in_touch = seen;
                // Ignored is tested first, then long wins over short.
                if (dur < min_thr)
                    r.end_kind = KIND_IGNORED;
                else if (dur >= long_thr)
                    r.end_kind = KIND_LONG;
                else if (dur <= short_thr)
                    r.end_kind = KIND_SHORT;
                else
                    r.end_kind = KIND_INVALID;
                active = 1'b0;
                start_ms = '0;
                seen = '0;
            end
            // Pad counts beyond the pad width saturate.
            n = (pad_cnt > PAD_BITS) ? PAD_BITS : int'(pad_cnt);
            lim = PAD_BITS'((32'd1 << n) - 1);
            r.pads_pressed  = mask & ~prev & lim;
            r.pads_released = ~mask & prev & lim;
            prev = mask;
            press_reports.push_back(r);
        endfunction

        function void mismatch(string field, logic [31:0] exp_val, logic [31:0] act_val);
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
            errors++;
        endfunction

        // Compares one accepted result word with the oldest prediction.
        function void check_word(logic [OUT_TDATA_W-1:0] word);
            result_t got;
            result_t exp;
            got = word[RESULT_W-1:0];
            if (press_reports.size() == 0)
            begin
                $display("%0t: unexpected result word 0x%0h", $time, word);
                errors++;
                return;
            end
            exp = press_reports.pop_front();
            if (got.touch_started !== exp.touch_started)
                mismatch("touch_started", exp.touch_started, got.touch_started);
            if (got.end_kind !== exp.end_kind)
                mismatch("end_kind", exp.end_kind, got.end_kind);
            if (got.duration_ms !== exp.duration_ms)
                mismatch("duration_ms", exp.duration_ms, got.duration_ms);
            if (got.pads_in_touch !== exp.pads_in_touch)
                mismatch("pads_in_touch", exp.pads_in_touch, got.pads_in_touch);
            if (got.pads_pressed !== exp.pads_pressed)
                mismatch("pads_pressed", exp.pads_pressed, got.pads_pressed);
            if (got.pads_released !== exp.pads_released)
                mismatch("pads_released", exp.pads_released, got.pads_released);
        endfunction

        function int pending();
            return press_reports.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]      cfg_index = '0;
    logic [THR_W-1:0]          cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;

    press_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int words_sent = 0;
    int stall_cycles = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    touch_press_classifier i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Result side: random stalls, or a long hold-off while one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offers one sample and waits until it is accepted; valid stays high afterwards.
    task automatic send_sample(input logic [PAD_BITS-1:0] mask, input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, now, mask};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_sample(mask, now);
        words_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    // One touch from start to release with the given duration.
    task automatic send_touch(input logic [PAD_BITS-1:0] mask, input logic [TIME_W-1:0] start,
                              input logic [TIME_W-1:0] dur);
        send_sample(mask, start);
        send_sample(13'h0, start + dur);
        clock_ms = start + dur;
    endtask

    // A touch whose duration lands near one of the thresholds or is random, with up to three samples inside.
    task automatic random_touch();
        logic [TIME_W-1:0]   base;
        logic [TIME_W-1:0]   dur;
        logic [TIME_W-1:0]   start;
        int                  mids;
        case ($urandom_range(0, 4))
            0: base = sb.min_thr;
            1: base = sb.short_thr;
            2: base = sb.long_thr;
            3: base = $urandom_range(0, 70000);
            default: base = $urandom;
        endcase
        dur = base + $urandom_range(0, 4) - 2;
        // Occasionally start just before the timestamp wraps.
        if ($urandom_range(0, 9) == 0)
            start = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else
            start = clock_ms + $urandom_range(1, 5000);
        send_sample(PAD_BITS'($urandom_range(1, 8191)), start);
        mids = $urandom_range(0, 3);
        for (int i = 0; i < mids; i++)
            send_sample(PAD_BITS'($urandom_range(1, 8191)), start + $urandom_range(0, 100));
        send_sample(13'h0, start + dur);
        clock_ms = start + dur;
        mids = $urandom_range(0, 2);
        for (int i = 0; i < mids; i++)
        begin
            clock_ms = clock_ms + $urandom_range(0, 50);
            send_sample(13'h0, clock_ms);
        end
    endtask

    // Touches at the long and short thresholds and just below the minimum of the current setting.
    task automatic threshold_touches();
        send_touch(PAD_BITS'($urandom_range(1, 8191)), $urandom, sb.long_thr);
        send_touch(PAD_BITS'($urandom_range(1, 8191)), $urandom, sb.short_thr);
        send_touch(PAD_BITS'($urandom_range(1, 8191)), $urandom, sb.min_thr - 1);
    endtask

    task automatic run_random(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(PAD_BITS'($urandom_range(0, 8191)), $urandom);
            else
                random_touch();
        end
        stop_sending();
    endtask

    // Waits until every predicted word has come back, then lets the pipeline settle.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [THR_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic write_config(input logic [THR_W-1:0] lng, input logic [THR_W-1:0] shrt,
                                input logic [THR_W-1:0] mn, input logic [PADC_W-1:0] pads);
        write_reg(REG_LONG_THRESHOLD, lng);
        write_reg(REG_SHORT_THRESHOLD, shrt);
        write_reg(REG_MIN_THRESHOLD, mn);
        write_reg(REG_PAD_COUNT, {{(THR_W - PADC_W){1'b0}}, pads});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset thresholds.
        send_sample(13'h1FFF, 32'h0);
        send_sample(13'h0, 32'd50);
        send_sample(13'h0001, 32'd1000);
        send_sample(13'h1000, 32'd1200);
        send_sample(13'h0, 32'd1300);
        send_touch(13'h0AAA, 32'd2000, 32'd3100);
        send_touch(13'h1555, 32'd10000, 32'd501);
        send_touch(13'h0040, 32'd20000, 32'd90);
        send_touch(13'h0003, 32'd21000, 32'd500);
        send_sample(13'h0100, 32'hFFFF_FF00);
        send_sample(13'h0100, 32'hFFFF_FFFF);
        send_sample(13'h0, 32'h0000_0100);
        send_touch(13'h0001, 32'h8000_0000, 32'd0);
        send_sample(13'h0, 32'd5);
        clock_ms = 32'd5;
        run_random(PHASE_WORDS);
        wait_drained();

        // Widest thresholds, no edges reported; long wins where short also holds.
        write_config(16'hFFFF, 16'hFFFF, 16'h0000, 4'd0);
        send_idle_pct = 74;
        threshold_touches();
        run_random(PHASE_WORDS);
        wait_drained();

        // Zero thresholds with a huge minimum, pad count beyond the pad width.
        write_config(16'h0000, 16'h0000, 16'hFFFF, 4'd15);
        send_idle_pct = 0;
        recv_idle_pct = 74;
        threshold_touches();
        run_random(PHASE_WORDS);
        wait_drained();

        // Random thresholds and pad count.
        write_config(THR_W'($urandom_range(0, 8000)), THR_W'($urandom_range(0, 4000)),
                     THR_W'($urandom_range(0, 300)), PADC_W'($urandom_range(1, 13)));
        send_idle_pct = 10;
        recv_idle_pct = 10;
        threshold_touches();
        run_random(PHASE_WORDS);
        wait_drained();

        // Long overlapping short, with a long result-side hold-off while samples keep coming.
        write_config(16'd200, 16'd300, 16'd10, 4'd5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        threshold_touches();
        hold_left = 300;
        run_random(PHASE_WORDS);
        wait_drained();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
